// ===== src/cc20_pkg.sv =====
package cc20_pkg;

    // Core sizes
    localparam int WORD_W            = 32;
    localparam int STATE_WORDS       = 16;
    localparam int BYTES_PER_ITEM    = 8;
    localparam int DATA_W            = 8 * BYTES_PER_ITEM;
    localparam int COUNT_W           = 4;
    localparam int ITEM_IDX_W        = 3;
    localparam int STEPS_PER_DROUND  = 8;
    localparam int DOUBLE_ROUNDS_DEF = 10;

    // Stream and register port widths
    localparam int TDATA_W = 72;
    localparam int CFG_W   = 64;
    localparam int ADDR_W  = 6;

    // ChaCha constant words ("expand 32-byte k")
    localparam logic [WORD_W-1:0] SIGMA0 = 32'h6170_7865;
    localparam logic [WORD_W-1:0] SIGMA1 = 32'h3320_646e;
    localparam logic [WORD_W-1:0] SIGMA2 = 32'h7962_2d32;
    localparam logic [WORD_W-1:0] SIGMA3 = 32'h6b20_6574;

    // Register map, one 64-bit register every 8 bytes
    typedef enum logic [2:0] {
        REG_KEY0    = 3'd0,
        REG_KEY1    = 3'd1,
        REG_KEY2    = 3'd2,
        REG_KEY3    = 3'd3,
        REG_NONCE_L = 3'd4,
        REG_NONCE_H = 3'd5,
        REG_START   = 3'd6
    } reg_idx_t;

    typedef logic [STATE_WORDS-1:0][WORD_W-1:0] state_t;

    // One keystream block on its way through the cell chain
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] ctr;
        state_t            st;
    } blk_t;

    // One message item riding alongside the chain
    typedef struct packed {
        logic                  valid;
        logic [DATA_W-1:0]     data;
        logic [COUNT_W-1:0]    count;
        logic                  last;
        logic [ITEM_IDX_W-1:0] idx;
    } item_t;

endpackage

// ===== src/cc20_cell.sv =====
module cc20_cell #(
    parameter int STEP = 0
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  cc20_pkg::blk_t blk_in,
    output cc20_pkg::blk_t blk_out
);

    // Step within a double round: low two bits pick the quarter-round line,
    // bit 2 picks column or diagonal placement.
    localparam int          SUB  = STEP % 4;
    localparam logic [1:0]  DIAG = (STEP % cc20_pkg::STEPS_PER_DROUND >= 4) ? 2'd1 : 2'd0;
    localparam int          ROT  = (SUB == 0) ? 16 : (SUB == 1) ? 12 : (SUB == 2) ? 8 : 7;

    cc20_pkg::blk_t blk_reg;

    // One add, xor and rotate on each of the four quarter rounds
    function automatic cc20_pkg::state_t qr_step(cc20_pkg::state_t s);
        cc20_pkg::state_t r;
        logic [3:0]  a;
        logic [3:0]  b;
        logic [3:0]  c;
        logic [3:0]  d;
        logic [31:0] x;
        logic [31:0] y;
        r = s;
        for (int j = 0; j < 4; j++) begin
            a = {2'b00, 2'(j)};
            b = {2'b01, 2'(2'(j) + DIAG)};
            c = {2'b10, 2'(2'(j) + 2'(DIAG << 1))};
            d = {2'b11, 2'(2'(j) + 2'(DIAG + (DIAG << 1)))};
            if (SUB == 0 || SUB == 2) begin
                x    = s[a] + s[b];
                y    = s[d] ^ x;
                r[a] = x;
                r[d] = (y << ROT) | (y >> (32 - ROT));
            end else begin
                x    = s[c] + s[d];
                y    = s[b] ^ x;
                r[c] = x;
                r[b] = (y << ROT) | (y >> (32 - ROT));
            end
        end
        return r;
    endfunction

    // Advance the block one step when the chain moves
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_reg.valid <= 1'b0;
        end else if (en) begin
            blk_reg.valid <= blk_in.valid;
            blk_reg.ctr   <= blk_in.ctr;
            blk_reg.st    <= qr_step(blk_in.st);
        end
    end

    assign blk_out = blk_reg;

endmodule

// ===== src/cc20_chain.sv =====
module cc20_chain #(
    parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  cc20_pkg::blk_t  blk_in,
    input  cc20_pkg::item_t item_in,
    output cc20_pkg::blk_t  blk_out,
    output cc20_pkg::item_t item_out
);

    localparam int STAGES = DOUBLE_ROUNDS * cc20_pkg::STEPS_PER_DROUND;

    cc20_pkg::blk_t  link [STAGES+1];
    cc20_pkg::item_t line_reg [STAGES];

    assign link[0] = blk_in;

    // Row of round-step cells
    for (genvar g = 0; g < STAGES; g++) begin : g_cell
        cc20_cell #(
            .STEP (g % cc20_pkg::STEPS_PER_DROUND)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .blk_in  (link[g]),
            .blk_out (link[g+1])
        );
    end

    // Delay the items by the same number of steps
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STAGES; i++) begin
                line_reg[i].valid <= 1'b0;
            end
        end else if (en) begin
            line_reg[0] <= item_in;
            for (int i = 1; i < STAGES; i++) begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign blk_out  = link[STAGES];
    assign item_out = line_reg[STAGES-1];

endmodule

// ===== src/chacha20_stream_xor.sv =====
// ChaCha20 keystream XOR for a byte stream, eight message bytes per item.
// Input items arrive on the s_ stream (data bytes and byte count in s_tdata,
// end of message on s_tlast); results leave on the m_ stream in the same
// order, one per item, unused bytes zeroed, count capped at eight and last flag
// copied. Key, nonce and start block counter sit in 64-bit registers on the
// APB port at byte addresses 0, 8, ... 48; write them only while no item
// is in flight.
// Throughput is one item per cycle while results are taken. Each block of 64
// keystream bytes is built by a chain of DOUBLE_ROUNDS*8 round-step cells, one
// add/xor/rotate each, launched by the first item of a block; the items ride a
// delay line of the same length, and a result item passes that line and then
// the output register before it can be taken.
// Reset clears the registers to zero, empties the chain and starts a new
// message with the next item. When the output register holds an item that is
// not taken, the whole chain holds and s_tready drops in that same cycle.
module chacha20_stream_xor #(
    parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cc20_pkg::TDATA_W-1:0]  s_tdata,  // [63:0] data_in, [67:64] byte_count
    input  logic                          s_tlast,
    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cc20_pkg::TDATA_W-1:0]  m_tdata,  // [63:0] data_out, [67:64] bytes_out
    output logic                          m_tlast,
    // Register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cc20_pkg::ADDR_W-1:0]   paddr,
    input  logic [cc20_pkg::CFG_W-1:0]    pwdata,
    output logic [cc20_pkg::CFG_W-1:0]    prdata,
    output logic                          pready
);

    localparam logic [cc20_pkg::COUNT_W-1:0] MAX_COUNT =
        cc20_pkg::COUNT_W'(cc20_pkg::BYTES_PER_ITEM);

    // Configuration registers
    logic [63:0] key0_reg, key1_reg, key2_reg, key3_reg, nonce_l_reg;
    logic [31:0] nonce_h_reg, start_reg;

    // Message state
    logic [31:0]                       block_cnt_reg, block_cnt_next;
    logic [cc20_pkg::ITEM_IDX_W-1:0]   pos_reg, pos_next;
    logic                              in_msg_reg, in_msg_next;

    // Datapath
    logic                       en;
    logic                       s_acc;
    logic                       cfg_wr;
    logic [31:0]                cur_cnt;
    logic [cc20_pkg::ITEM_IDX_W-1:0] cur_idx;
    logic [cc20_pkg::COUNT_W-1:0]    in_count;
    cc20_pkg::blk_t             blk_front, blk_back;
    cc20_pkg::item_t            item_front, item_back;
    cc20_pkg::state_t           ks_new;
    cc20_pkg::state_t           ks_buf_reg;
    cc20_pkg::state_t           init_back;
    logic [63:0]                ks_item;
    logic [63:0]                xor_data;

    logic                              m_valid_reg;
    logic [63:0]                       m_data_reg;
    logic [cc20_pkg::COUNT_W-1:0]      m_count_reg;
    logic                              m_last_reg;

    // Block function input words
    function automatic cc20_pkg::state_t init_state(
        logic [63:0] k0, logic [63:0] k1, logic [63:0] k2, logic [63:0] k3,
        logic [63:0] nl, logic [31:0] nh, logic [31:0] ctr
    );
        cc20_pkg::state_t s;
        s[0]  = cc20_pkg::SIGMA0;
        s[1]  = cc20_pkg::SIGMA1;
        s[2]  = cc20_pkg::SIGMA2;
        s[3]  = cc20_pkg::SIGMA3;
        s[4]  = k0[31:0];
        s[5]  = k0[63:32];
        s[6]  = k1[31:0];
        s[7]  = k1[63:32];
        s[8]  = k2[31:0];
        s[9]  = k2[63:32];
        s[10] = k3[31:0];
        s[11] = k3[63:32];
        s[12] = ctr;
        s[13] = nl[31:0];
        s[14] = nl[63:32];
        s[15] = nh;
        return s;
    endfunction

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key0_reg    <= '0;
            key1_reg    <= '0;
            key2_reg    <= '0;
            key3_reg    <= '0;
            nonce_l_reg <= '0;
            nonce_h_reg <= '0;
            start_reg   <= '0;
        end else if (cfg_wr) begin
            unique case (cc20_pkg::reg_idx_t'(paddr[5:3]))
                cc20_pkg::REG_KEY0:    key0_reg    <= pwdata;
                cc20_pkg::REG_KEY1:    key1_reg    <= pwdata;
                cc20_pkg::REG_KEY2:    key2_reg    <= pwdata;
                cc20_pkg::REG_KEY3:    key3_reg    <= pwdata;
                cc20_pkg::REG_NONCE_L: nonce_l_reg <= pwdata;
                cc20_pkg::REG_NONCE_H: nonce_h_reg <= pwdata[31:0];
                cc20_pkg::REG_START:   start_reg   <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cc20_pkg::reg_idx_t'(paddr[5:3]))
            cc20_pkg::REG_KEY0:    prdata = key0_reg;
            cc20_pkg::REG_KEY1:    prdata = key1_reg;
            cc20_pkg::REG_KEY2:    prdata = key2_reg;
            cc20_pkg::REG_KEY3:    prdata = key3_reg;
            cc20_pkg::REG_NONCE_L: prdata = nonce_l_reg;
            cc20_pkg::REG_NONCE_H: prdata = {32'd0, nonce_h_reg};
            cc20_pkg::REG_START:   prdata = {32'd0, start_reg};
            default:               prdata = '0;
        endcase
    end

    // Chain moves whenever the output register is free or being drained
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;
    assign s_acc    = s_tvalid && s_tready;

    // Front: pick the block counter and item slot, launch a block on slot zero
    assign cur_cnt  = in_msg_reg ? block_cnt_reg : start_reg;
    assign cur_idx  = in_msg_reg ? pos_reg : '0;
    assign in_count = (s_tdata[67:64] > MAX_COUNT) ? MAX_COUNT : s_tdata[67:64];

    always_comb begin
        block_cnt_next = block_cnt_reg;
        pos_next       = pos_reg;
        in_msg_next    = in_msg_reg;
        if (s_acc) begin
            block_cnt_next = (cur_idx == '0) ? cur_cnt + 32'd1 : cur_cnt;
            pos_next       = cur_idx + cc20_pkg::ITEM_IDX_W'(1);
            in_msg_next    = !s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_cnt_reg <= '0;
            pos_reg       <= '0;
            in_msg_reg    <= 1'b0;
        end else begin
            block_cnt_reg <= block_cnt_next;
            pos_reg       <= pos_next;
            in_msg_reg    <= in_msg_next;
        end
    end

    assign blk_front.valid = s_acc && (cur_idx == '0);
    assign blk_front.ctr   = cur_cnt;
    assign blk_front.st    = init_state(key0_reg, key1_reg, key2_reg, key3_reg,
                                        nonce_l_reg, nonce_h_reg, cur_cnt);

    assign item_front.valid = s_acc;
    assign item_front.data  = s_tdata[63:0];
    assign item_front.count = in_count;
    assign item_front.last  = s_tlast;
    assign item_front.idx   = cur_idx;

    cc20_chain #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .blk_in   (blk_front),
        .item_in  (item_front),
        .blk_out  (blk_back),
        .item_out (item_back)
    );

    // Back: feed-forward add, keystream words for this item
    assign init_back = init_state(key0_reg, key1_reg, key2_reg, key3_reg,
                                  nonce_l_reg, nonce_h_reg, blk_back.ctr);

    always_comb begin
        for (int i = 0; i < cc20_pkg::STATE_WORDS; i++) begin
            ks_new[i] = blk_back.st[i] + init_back[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en && blk_back.valid) begin
            ks_buf_reg <= ks_new;
        end
    end

    assign ks_item = (item_back.idx == '0) ? {ks_new[1], ks_new[0]}
                   : {ks_buf_reg[{item_back.idx, 1'b1}], ks_buf_reg[{item_back.idx, 1'b0}]};

    // Mask bytes beyond the count
    always_comb begin
        for (int i = 0; i < cc20_pkg::BYTES_PER_ITEM; i++) begin
            xor_data[8*i +: 8] = (cc20_pkg::COUNT_W'(i) < item_back.count)
                               ? (item_back.data[8*i +: 8] ^ ks_item[8*i +: 8]) : 8'd0;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= item_back.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg  <= xor_data;
            m_count_reg <= item_back.count;
            m_last_reg  <= item_back.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_count_reg, m_data_reg};
    assign m_tlast  = m_last_reg;

    // A block leaves the chain exactly with the first item of its block
    a_blk_with_item: assert property (@(posedge aclk) disable iff (!aresetn)
        blk_back.valid |-> item_back.valid && item_back.idx == '0)
        else $error("keystream block without its first item");

    a_item_with_blk: assert property (@(posedge aclk) disable iff (!aresetn)
        item_back.valid && item_back.idx == '0 |-> blk_back.valid)
        else $error("first item of a block without keystream");

    a_last_ends_msg: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tlast |=> !in_msg_reg)
        else $error("message still open after final item");

    a_new_msg_launch: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && !in_msg_reg |-> blk_front.valid && blk_front.ctr == start_reg)
        else $error("message start did not launch the start block");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_count_reg <= MAX_COUNT)
        else $error("byte count above item size");

endmodule
